### rtl/its_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_pkg
// Shared types, constants and helper functions of the identifier token
// sanitizer.
// ----------------------------------------------------------------------------
package its_pkg;

    localparam int OUT_CAPACITY_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int CNT_W            = 6;

    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_NONE       = 8'h00;

    localparam logic [CNT_W-1:0] DEFAULT_LEN  = 6'd3;
    localparam logic [CNT_W-1:0] DEFAULT_LAST = 6'd2;

    typedef struct packed {
        logic [CNT_W-1:0] pend;
        logic             has_char;
        logic [7:0]       ch;
        logic             is_end;
        logic             dflt;
        logic [CNT_W-1:0] len;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEND,
        ST_CHAR,
        ST_DEF,
        ST_END
    } t_back_state;

    function automatic logic byte_allowed(input logic [7:0] c);
        logic ok;
        ok = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DASH) ||
             (c == CH_UNDERSCORE) || (c == CH_DOT) || (c == CH_COLON);
        return ok;
    endfunction

    function automatic logic [7:0] default_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: begin
                c = 8'h6D;
            end
            2'd1: begin
                c = 8'h73;
            end
            2'd2: begin
                c = 8'h67;
            end
            default: begin
                c = CH_NONE;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/its_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_front
// Accepts input bytes, applies truncation and the character filter, tracks
// the token state and makes a request for each kept byte and token end.
// ----------------------------------------------------------------------------
module its_front #(
    parameter int P_OUT_CAPACITY = its_pkg::OUT_CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [its_pkg::CNT_W-1:0] i_max_length,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [7:0]               i_in_char,
    input  wire logic                     i_char_present,
    input  wire logic                     i_is_last,
    input  wire logic                     i_q_full,
    output logic                          o_q_push,
    output its_pkg::t_cmd                 o_q_data
);
    import its_pkg::*;

    localparam logic [CNT_W-1:0] CAP_LEN = CNT_W'(P_OUT_CAPACITY - 1);

    logic [CNT_W-1:0] r_accepted, n_accepted;
    logic [CNT_W-1:0] r_pending, n_pending;
    logic [CNT_W-1:0] r_emitted, n_emitted;
    logic             r_seen, n_seen;

    logic [CNT_W-1:0] limit;
    logic             accept;
    logic             take;
    logic [7:0]       clean_char;
    logic             push_char;
    t_cmd             cmd;

    assign limit  = ((i_max_length == '0) || (i_max_length > CAP_LEN)) ? CAP_LEN
                                                                       : i_max_length;
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = i_char_present && (r_accepted < limit);
    assign clean_char = byte_allowed(i_in_char) ? i_in_char : CH_UNDERSCORE;
    assign push_char  = take && (clean_char != CH_UNDERSCORE);

    always_comb begin
        n_accepted = r_accepted;
        n_pending  = r_pending;
        n_emitted  = r_emitted;
        n_seen     = r_seen;
        cmd.pend     = '0;
        cmd.has_char = 1'b0;
        cmd.ch       = clean_char;
        cmd.is_end   = i_is_last;
        cmd.dflt     = 1'b0;
        cmd.len      = '0;
        if (take) begin
            n_accepted = r_accepted + 1'b1;
            if (clean_char == CH_UNDERSCORE) begin
                if (r_seen) begin
                    n_pending = r_pending + 1'b1;
                end
            end else begin
                cmd.pend     = r_pending;
                cmd.has_char = 1'b1;
                n_emitted    = r_emitted + r_pending + 1'b1;
                n_pending    = '0;
                n_seen       = 1'b1;
            end
        end
        if (i_is_last) begin
            if (n_emitted == '0) begin
                cmd.dflt = 1'b1;
                cmd.len  = DEFAULT_LEN;
            end else begin
                cmd.len = n_emitted;
            end
            n_accepted = '0;
            n_pending  = '0;
            n_emitted  = '0;
            n_seen     = 1'b0;
        end
    end

    assign o_q_push = accept && (push_char || i_is_last);
    assign o_q_data = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted <= '0;
            r_pending  <= '0;
            r_emitted  <= '0;
            r_seen     <= 1'b0;
        end else if (accept) begin
            r_accepted <= n_accepted;
            r_pending  <= n_pending;
            r_emitted  <= n_emitted;
            r_seen     <= n_seen;
        end
    end

endmodule
`default_nettype wire

### rtl/its_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module its_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire its_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output its_pkg::t_cmd      o_head,
    output logic               o_empty
);
    import its_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wptr, n_wptr;
    logic [QW-1:0] r_rptr, n_rptr;
    logic [QW:0]   r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = do_push ? QW'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_pop ? QW'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count + (QW+1)'(do_push) - (QW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QW+1)'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("Queue count did not follow a push.");
    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("Queue count did not follow a pop.");

endmodule
`default_nettype wire

### rtl/its_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// its_back
// Expands each request into output results: held underscores, the byte,
// the default token and the end marker, through a registered output stage.
// ----------------------------------------------------------------------------
module its_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire its_pkg::t_cmd             i_head,
    input  wire logic                      i_empty,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [7:0]                     o_out_char,
    output logic                           o_out_present,
    output logic                           o_end_of_token,
    output logic [its_pkg::CNT_W-1:0]      o_token_length,
    output logic                           o_used_default
);
    import its_pkg::*;

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_present;
    logic             r_end;
    logic [CNT_W-1:0] r_len;
    logic             r_dflt;

    logic             load_ok;
    logic             step;
    logic             fin;
    logic [7:0]       e_char;
    logic             e_present;
    logic             e_end;
    logic [CNT_W-1:0] e_len;
    logic             e_dflt;

    assign load_ok = !r_out_valid || i_out_ready;
    assign step    = (r_state != ST_IDLE) && load_ok;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        fin     = 1'b0;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_PEND: begin
                if (step) begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == 6'd1) begin
                        n_state = ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                if (step) begin
                    if (r_cmd.is_end) begin
                        n_state = ST_END;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            ST_DEF: begin
                if (step) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == DEFAULT_LAST) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (step) begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (fin) begin
            n_state = ST_IDLE;
            o_pop   = !i_empty;
        end
        if (o_pop) begin
            n_cmd = i_head;
            n_cnt = i_head.pend;
            if (i_head.pend != '0) begin
                n_state = ST_PEND;
            end else if (i_head.has_char) begin
                n_state = ST_CHAR;
            end else if (i_head.dflt) begin
                n_state = ST_DEF;
            end else begin
                n_state = ST_END;
            end
        end
    end

    always_comb begin
        e_char    = CH_NONE;
        e_present = 1'b0;
        e_end     = 1'b0;
        e_len     = '0;
        e_dflt    = 1'b0;
        case (r_state)
            ST_PEND: begin
                e_char    = CH_UNDERSCORE;
                e_present = 1'b1;
            end
            ST_CHAR: begin
                e_char    = r_cmd.ch;
                e_present = 1'b1;
            end
            ST_DEF: begin
                e_char    = default_char(r_cnt[1:0]);
                e_present = 1'b1;
                e_dflt    = 1'b1;
            end
            ST_END: begin
                e_end  = 1'b1;
                e_len  = r_cmd.len;
                e_dflt = r_cmd.dflt;
            end
            default: begin
                e_char = CH_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= step || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (step) begin
            r_out_char    <= e_char;
            r_out_present <= e_present;
            r_end         <= e_end;
            r_len         <= e_len;
            r_dflt        <= e_dflt;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_out_present  = r_out_present;
    assign o_end_of_token = r_end;
    assign o_token_length = r_len;
    assign o_used_default = r_dflt;

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("Back end popped an empty queue.");
    a_def_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEF) |-> (r_cnt <= DEFAULT_LAST))
        else $error("Default token index out of range.");
    a_pend_to_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && (r_state == ST_PEND) && (r_cnt == 6'd1)) |=> (r_state == ST_CHAR))
        else $error("Held underscores were not followed by their byte.");

endmodule
`default_nettype wire

### rtl/id_token_sanitizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id_token_sanitizer_core
// Streaming identifier token cleaner: truncates, filters characters, drops
// leading and trailing underscores and ends each token with a length marker.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   char, present, last flag
//   output    out        o_out_valid / i_out_ready char, present, end, length, default
//   config    in         APB psel/penable/pready   max_length at address 0
//
// The front end takes one item per cycle while the request queue has room.
// The back end emits one result per held underscore, one for the byte, and
// one for the end marker (four with the default token). Synchronous reset
// clears all token state and the queue; max_length resets to zero. The output
// register holds a result while i_out_ready is low, and the queue lets the
// front end keep accepting until it is full.
// ----------------------------------------------------------------------------
module id_token_sanitizer_core #(
    parameter int P_OUT_CAPACITY = its_pkg::OUT_CAPACITY_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [its_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [its_pkg::APB_DATA_W-1:0] pwdata,
    output logic [its_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_in_char,
    input  wire logic                           i_char_present,
    input  wire logic                           i_is_last,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [7:0]                          o_out_char,
    output logic                                o_out_present,
    output logic                                o_end_of_token,
    output logic [its_pkg::CNT_W-1:0]           o_token_length,
    output logic                                o_used_default
);
    import its_pkg::*;

    logic [CNT_W-1:0] r_max_length;
    logic             reg_sel;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    t_cmd             q_in;
    t_cmd             q_head;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_MAX_LENGTH);
    assign prdata  = reg_sel ? APB_DATA_W'(r_max_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_length <= pwdata[CNT_W-1:0];
        end
    end

    its_front #(
        .P_OUT_CAPACITY(P_OUT_CAPACITY)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_length   (r_max_length),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_char      (i_in_char),
        .i_char_present (i_char_present),
        .i_is_last      (i_is_last),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    its_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    its_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_out_present  (o_out_present),
        .o_end_of_token (o_end_of_token),
        .o_token_length (o_token_length),
        .o_used_default (o_used_default)
    );

endmodule
`default_nettype wire
